@@ hw/rtl/scs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants for the sine / cosine series block
// Fixed-point constants for range reduction, per-term divisor tables and
// the sequencer state type.
// ----------------------------------------------------------------------------
package scs_pkg;

    // field widths
    localparam int ANG_W = 32;
    localparam int VAL_W = 32;
    localparam int A_W   = 41;   // angle in Q.32 plus pi/2, signed
    localparam int MAG_W = 40;   // magnitude of that word
    localparam int RED_W = 35;   // reduced angle, below 2*pi in Q.32
    localparam int SUM_W = 34;   // series sum, signed
    localparam int DEN_W = 11;   // largest divisor 32*33

    // range reduction constants in Q.32, rounded down
    localparam logic [RED_W-1:0] HALF_PI_Q32       = 35'd6746518852;
    localparam logic [RED_W-1:0] PI_Q32            = 35'd13493037704;
    localparam logic [RED_W-1:0] THREE_HALF_PI_Q32 = 35'd20239556556;
    localparam logic [RED_W-1:0] TWO_PI_Q32        = 35'd26986075409;

    // compare-subtract passes for the modulo: 2*pi << 5 down to 2*pi << 0
    localparam int RED_STEPS = 6;

    localparam logic signed [SUM_W-1:0] ONE_Q30 = 34'sd1073741824;

    // deepest series the tables cover
    localparam int TERMS_MAX = 16;

    // divisor (2i)(2i+1) for term i, stored at i-1
    localparam logic [DEN_W-1:0] DEN_TAB [TERMS_MAX] = '{
        11'd6,   11'd20,  11'd42,  11'd72,  11'd110, 11'd156, 11'd210, 11'd272,
        11'd342, 11'd420, 11'd506, 11'd600, 11'd702, 11'd812, 11'd930, 11'd1056
    };

    // floor(2^32 / divisor), the estimate is at most two low
    localparam logic [31:0] RECIP_TAB [TERMS_MAX] = '{
        32'((64'd1 << 32) / 64'd6),    32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd42),   32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd110),  32'((64'd1 << 32) / 64'd156),
        32'((64'd1 << 32) / 64'd210),  32'((64'd1 << 32) / 64'd272),
        32'((64'd1 << 32) / 64'd342),  32'((64'd1 << 32) / 64'd420),
        32'((64'd1 << 32) / 64'd506),  32'((64'd1 << 32) / 64'd600),
        32'((64'd1 << 32) / 64'd702),  32'((64'd1 << 32) / 64'd812),
        32'((64'd1 << 32) / 64'd930),  32'((64'd1 << 32) / 64'd1056)
    };

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS,
        ST_RED,
        ST_FOLD,
        ST_XCONV,
        ST_SQR,
        ST_X2,
        ST_TMUL,
        ST_TNUM,
        ST_TREC,
        ST_TBAK,
        ST_TREM,
        ST_TFIX,
        ST_CLAMP,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

@@ hw/rtl/scs_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs_mul: shared 32 x 32 unsigned multiplier
// Product is registered; operands presented in one cycle give the product
// on the next.
// ----------------------------------------------------------------------------
module scs_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_prod
);

    logic [63:0] r_prod;

    // registered product
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

@@ hw/rtl/sine_cosine_series.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sine_cosine_series: fixed-point sine / cosine by Taylor series
// Angle in Q8.24 radians, result in Q2.30 saturated to +/-1.0.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall | i_op, i_angle (Q8.24)
//  out     | output    | o_out_valid/ i_out_stall| o_value (Q2.30)
//
//  one beat runs up to SERIES_TERMS series terms, fewer once a term is
//  zero: the shared multiplier is used three times per term, and the modulo
//  takes 6 compare-subtract passes.
//  o_in_stall is high from acceptance until the result enters the output
//  register; a result waiting on i_out_stall holds the block in its last state.
//  reset is synchronous, active low, and clears the sequencer and out valid.
// ----------------------------------------------------------------------------
module sine_cosine_series #(
    parameter int SERIES_TERMS = 11
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_op,
    input  wire logic signed [31:0] i_angle,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [31:0] o_value
);

    localparam int IW = $clog2(SERIES_TERMS + 1);

    scs_pkg::t_state r_state;
    scs_pkg::t_state n_state;

    logic [scs_pkg::A_W-1:0]   r_a;
    logic [scs_pkg::MAG_W-1:0] r_mag;
    logic [2:0]                r_k;
    logic [scs_pkg::RED_W-1:0] r_red;
    logic                      r_neg;
    logic [31:0]               r_t;
    logic [31:0]               r_x2;
    logic [31:0]               r_num;
    logic [31:0]               r_rem;
    logic [IW-1:0]             r_i;
    logic signed [scs_pkg::SUM_W-1:0] r_sum;
    logic signed [31:0]        r_clamp;
    logic                      r_out_valid;
    logic signed [31:0]        r_value;

    logic [31:0]               w_mul_a;
    logic [31:0]               w_mul_b;
    logic [63:0]               w_prod;
    logic [3:0]                w_tidx;
    logic [scs_pkg::DEN_W-1:0] w_den;
    logic [31:0]               w_recip;
    logic [scs_pkg::MAG_W-1:0] w_red_sub;
    logic [scs_pkg::RED_W-1:0] w_fold;
    logic                      w_fold_flip;
    logic [31:0]               w_x;
    logic                      w_in_acc;
    logic                      w_out_free;
    logic                      w_fix_done;
    logic                      w_last;

    // shared multiplier
    scs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // per-term constants
    assign w_tidx  = 4'(r_i - IW'(1));
    assign w_den   = scs_pkg::DEN_TAB[w_tidx];
    assign w_recip = scs_pkg::RECIP_TAB[w_tidx];

    // modulo pass: 2*pi scaled by the current power of two
    assign w_red_sub = scs_pkg::MAG_W'(scs_pkg::TWO_PI_Q32) << r_k;

    // fold the reduced magnitude into 0..pi/2
    always_comb begin
        w_fold      = r_mag[scs_pkg::RED_W-1:0];
        w_fold_flip = 1'b0;
        if (r_mag[scs_pkg::RED_W-1:0] <= scs_pkg::HALF_PI_Q32) begin
            w_fold = r_mag[scs_pkg::RED_W-1:0];
        end else if (r_mag[scs_pkg::RED_W-1:0] <= scs_pkg::PI_Q32) begin
            w_fold = scs_pkg::PI_Q32 - r_mag[scs_pkg::RED_W-1:0];
        end else if (r_mag[scs_pkg::RED_W-1:0] <= scs_pkg::THREE_HALF_PI_Q32) begin
            w_fold      = r_mag[scs_pkg::RED_W-1:0] - scs_pkg::PI_Q32;
            w_fold_flip = 1'b1;
        end else begin
            w_fold      = scs_pkg::TWO_PI_Q32 - r_mag[scs_pkg::RED_W-1:0];
            w_fold_flip = 1'b1;
        end
    end

    // q.32 to q2.30, half up
    assign w_x = 32'((36'(r_red) + 36'd2) >> 2);

    assign w_in_acc   = i_in_valid && (r_state == scs_pkg::ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fix_done = r_rem < 32'(w_den);
    assign w_last     = (r_t == 32'd0) || (r_i == IW'(SERIES_TERMS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            scs_pkg::ST_IDLE:  if (i_in_valid) n_state = scs_pkg::ST_ABS;
            scs_pkg::ST_ABS:   n_state = scs_pkg::ST_RED;
            scs_pkg::ST_RED:   if (r_k == 3'd0) n_state = scs_pkg::ST_FOLD;
            scs_pkg::ST_FOLD:  n_state = scs_pkg::ST_XCONV;
            scs_pkg::ST_XCONV: n_state = scs_pkg::ST_SQR;
            scs_pkg::ST_SQR:   n_state = scs_pkg::ST_X2;
            scs_pkg::ST_X2:    n_state = scs_pkg::ST_TMUL;
            scs_pkg::ST_TMUL:  n_state = scs_pkg::ST_TNUM;
            scs_pkg::ST_TNUM:  n_state = scs_pkg::ST_TREC;
            scs_pkg::ST_TREC:  n_state = scs_pkg::ST_TBAK;
            scs_pkg::ST_TBAK:  n_state = scs_pkg::ST_TREM;
            scs_pkg::ST_TREM:  n_state = scs_pkg::ST_TFIX;
            scs_pkg::ST_TFIX: begin
                if (w_fix_done) begin
                    n_state = w_last ? scs_pkg::ST_CLAMP : scs_pkg::ST_TMUL;
                end
            end
            scs_pkg::ST_CLAMP: n_state = scs_pkg::ST_FIN;
            scs_pkg::ST_FIN:   if (w_out_free) n_state = scs_pkg::ST_IDLE;
            default:           n_state = scs_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operands and input stall
    always_comb begin
        w_mul_a = 32'd0;
        w_mul_b = 32'd0;
        case (r_state)
            scs_pkg::ST_SQR: begin
                w_mul_a = r_t;
                w_mul_b = r_t;
            end
            scs_pkg::ST_TMUL: begin
                w_mul_a = r_t;
                w_mul_b = r_x2;
            end
            scs_pkg::ST_TREC: begin
                w_mul_a = r_num;
                w_mul_b = w_recip;
            end
            scs_pkg::ST_TBAK: begin
                w_mul_a = w_prod[63:32];
                w_mul_b = 32'(w_den);
            end
            default: begin
                w_mul_a = 32'd0;
                w_mul_b = 32'd0;
            end
        endcase
    end

    assign o_in_stall = (r_state != scs_pkg::ST_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            scs_pkg::ST_IDLE: begin
                // angle to q.32, cosine adds pi/2
                if (w_in_acc) begin
                    r_a <= {i_angle[31], i_angle, 8'd0}
                         + (i_op ? scs_pkg::A_W'(scs_pkg::HALF_PI_Q32)
                                 : scs_pkg::A_W'(0));
                end
            end
            scs_pkg::ST_ABS: begin
                r_neg <= r_a[scs_pkg::A_W-1];
                r_mag <= r_a[scs_pkg::A_W-1] ? scs_pkg::MAG_W'(-r_a)
                                              : scs_pkg::MAG_W'(r_a);
                r_k   <= 3'(scs_pkg::RED_STEPS - 1);
            end
            scs_pkg::ST_RED: begin
                if (r_mag >= w_red_sub) begin
                    r_mag <= r_mag - w_red_sub;
                end
                r_k <= r_k - 3'd1;
            end
            scs_pkg::ST_FOLD: begin
                r_red <= w_fold;
                r_neg <= r_neg ^ w_fold_flip;
            end
            scs_pkg::ST_XCONV: begin
                r_t   <= w_x;
                r_sum <= scs_pkg::SUM_W'(w_x);
            end
            scs_pkg::ST_X2: begin
                r_x2 <= 32'((w_prod + (64'd1 << 29)) >> 30);
                r_i  <= IW'(1);
            end
            scs_pkg::ST_TNUM: begin
                r_num <= 32'((w_prod + (64'(w_den) << 29)) >> 30);
            end
            scs_pkg::ST_TBAK: begin
                r_t <= w_prod[63:32];
            end
            scs_pkg::ST_TREM: begin
                r_rem <= r_num - w_prod[31:0];
            end
            scs_pkg::ST_TFIX: begin
                // bump the quotient estimate until the remainder fits
                if (!w_fix_done) begin
                    r_t   <= r_t + 32'd1;
                    r_rem <= r_rem - 32'(w_den);
                end else begin
                    // odd terms subtract, even terms add
                    if (r_i[0]) begin
                        r_sum <= r_sum - scs_pkg::SUM_W'(r_t);
                    end else begin
                        r_sum <= r_sum + scs_pkg::SUM_W'(r_t);
                    end
                    r_i <= r_i + IW'(1);
                end
            end
            scs_pkg::ST_CLAMP: begin
                if (r_sum > scs_pkg::ONE_Q30) begin
                    r_clamp <= 32'(scs_pkg::ONE_Q30);
                end else if (r_sum < -scs_pkg::ONE_Q30) begin
                    r_clamp <= 32'(-scs_pkg::ONE_Q30);
                end else begin
                    r_clamp <= 32'(r_sum);
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == scs_pkg::ST_FIN && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == scs_pkg::ST_FIN && w_out_free) begin
            r_value <= r_neg ? -r_clamp : r_clamp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;

    // accepted beat blocks further input on the next cycle
    a_acc_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted but stall not raised");

    // modulo leaves the magnitude below 2*pi
    a_red_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scs_pkg::ST_FOLD) |->
            (r_mag < scs_pkg::MAG_W'(scs_pkg::TWO_PI_Q32)))
        else $error("reduced angle out of range");

    // term counter stays within the series length
    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scs_pkg::ST_TFIX) |->
            (r_i >= IW'(1) && r_i <= IW'(SERIES_TERMS)))
        else $error("term counter out of range");

    // reciprocal estimate is never more than a few divisors low
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scs_pkg::ST_TFIX) |-> (r_rem < (32'(w_den) << 2)))
        else $error("quotient correction out of bounds");

    // result beat is saturated to +/-1.0
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_value <= 32'sd1073741824 && o_value >= -32'sd1073741824))
        else $error("result beyond unit range");

endmodule
`default_nettype wire

@@ tb/tb_sine_cosine_series.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sine_cosine_series: self-checking bench for the sine / cosine series block
// Drives op / angle beats through a short directed table and then a long
// random run, predicts each Q2.30 value in fixed point and checks every
// output beat in order, with random idling on both channels and one long
// output hold-off that backs the input channel up.
// ----------------------------------------------------------------------------
module tb_sine_cosine_series;

    localparam int SERIES_TERMS = 11;
    localparam int N_RANDOM     = 1550;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 120;

    // angle landmarks in Q8.24
    localparam logic [31:0] A_HALF_PI  = 32'd26353589;
    localparam logic [31:0] A_PI       = 32'd52707179;
    localparam logic [31:0] A_3HALF_PI = 32'd79060768;
    localparam logic [31:0] A_TWO_PI   = 32'd105414357;

    // reduction constants widened to 64 bits
    localparam logic [63:0] C_HALF_PI  = 64'(scs_pkg::HALF_PI_Q32);
    localparam logic [63:0] C_PI       = 64'(scs_pkg::PI_Q32);
    localparam logic [63:0] C_3HALF_PI = 64'(scs_pkg::THREE_HALF_PI_Q32);
    localparam logic [63:0] C_TWO_PI   = 64'(scs_pkg::TWO_PI_Q32);
    localparam longint      C_ONE      = 64'sd1073741824;

    // idle percentages per phase, sender and receiver
    localparam int SND_IDLE_PCT [3] = '{19, 69, 0};
    localparam int RCV_IDLE_PCT [3] = '{69, 19, 0};

    typedef enum logic {
        OP_SIN = 1'b0,
        OP_COS = 1'b1
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] angle;
        logic        known;
        logic [31:0] value;
    } t_stim_row;

    typedef struct {
        logic [31:0] value;
        t_op         op;
        logic [31:0] angle;
    } t_due_value;

    localparam int N_DIRECTED = 23;

    // directed beats; value is typed in only where it is obvious
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{OP_SIN, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{OP_COS, 32'h0000_0000, 1'b0, 32'h0},
        '{OP_SIN, 32'h0000_0001, 1'b0, 32'h0},
        '{OP_SIN, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{OP_COS, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{OP_SIN, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{OP_SIN, 32'h8000_0000, 1'b0, 32'h0},
        '{OP_COS, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{OP_COS, 32'h8000_0000, 1'b0, 32'h0},
        '{OP_SIN, A_HALF_PI,     1'b0, 32'h0},
        '{OP_SIN, -A_HALF_PI,    1'b0, 32'h0},
        '{OP_SIN, A_PI,          1'b0, 32'h0},
        '{OP_SIN, A_PI + 32'd1,  1'b0, 32'h0},
        '{OP_COS, A_PI,          1'b0, 32'h0},
        '{OP_SIN, A_3HALF_PI,    1'b0, 32'h0},
        '{OP_SIN, A_TWO_PI,      1'b0, 32'h0},
        '{OP_SIN, -A_TWO_PI,     1'b0, 32'h0},
        '{OP_COS, -A_PI,         1'b0, 32'h0},
        '{OP_SIN, 32'h5555_5555, 1'b0, 32'h0},
        '{OP_COS, 32'hAAAA_AAAA, 1'b0, 32'h0},
        '{OP_COS, 32'h00FF_FFFF, 1'b0, 32'h0},
        '{OP_SIN, 32'h0100_0000, 1'b0, 32'h0},
        '{OP_COS, 32'hFF00_0000, 1'b0, 32'h0}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_op        = 1'b0;
    logic [31:0] i_angle     = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_value;

    int          phase     = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          fail_cnt  = 0;
    t_due_value  due_values [$];

    sine_cosine_series #(
        .SERIES_TERMS(SERIES_TERMS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (i_op),
        .i_angle    (i_angle),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_value    (o_value)
    );

    // clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // fixed-point sine of a magnitude in Q2.30, series stops on a zero term
    function automatic longint sine_sum(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] den;
        longint      sum;
        bit          minus;
        x2    = (x * x + (64'd1 << 29)) >> 30;
        t     = x;
        sum   = longint'(x);
        minus = 1'b0;
        for (int i = 1; i <= SERIES_TERMS; i++) begin
            den   = 64'(2 * i) * 64'(2 * i + 1);
            t     = (t * x2 + (den << 29)) / (den << 30);
            minus = !minus;
            if (minus) sum -= longint'(t);
            else       sum += longint'(t);
            if (t == 64'd0) break;
        end
        return sum;
    endfunction

    // expected Q2.30 value for one beat
    function automatic logic [31:0] series_value(input t_op op, input logic [31:0] angle);
        longint      a;
        longint      r;
        longint      sum;
        logic [63:0] mag;
        bit          negative;
        a = longint'($signed(angle)) * 256;
        if (op == OP_COS) a += longint'(C_HALF_PI);
        negative = (a < 0);
        mag = negative ? 64'(-a) : 64'(a);
        mag = mag % C_TWO_PI;
        // fold into -pi/2..pi/2
        if (mag > C_HALF_PI && mag <= C_3HALF_PI) begin
            r = longint'(C_PI) - longint'(mag);
        end else if (mag > C_3HALF_PI) begin
            r = longint'(C_TWO_PI - mag);
            negative = !negative;
        end else begin
            r = longint'(mag);
        end
        // odd symmetry keeps the series on a non-negative argument
        if (r < 0) begin
            r = -r;
            negative = !negative;
        end
        sum = sine_sum((64'(r) + 64'd2) >> 2);
        if (sum > C_ONE)  sum = C_ONE;
        if (sum < -C_ONE) sum = -C_ONE;
        if (negative) sum = -sum;
        return sum[31:0];
    endfunction

    // random angle, weighted toward fold points, small and extreme values
    function automatic logic [31:0] random_angle();
        longint base;
        int     kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: begin
                base = longint'($urandom());
            end
            4, 5: begin
                base = (longint'($urandom_range(0, 162)) - 81) * longint'(A_HALF_PI)
                       + longint'($urandom_range(0, 64)) - 32;
            end
            6, 7: begin
                base = longint'($urandom_range(0, 2097152)) - 1048576;
            end
            8: begin
                if ($urandom_range(0, 1) == 0)
                    base = 64'sd2147483647 - longint'($urandom_range(0, 4095));
                else
                    base = -64'sd2147483648 + longint'($urandom_range(0, 4095));
            end
            default: begin
                base = longint'($urandom_range(0, 512)) - 256;
            end
        endcase
        return base[31:0];
    endfunction

    // offer one beat after a random gap, record its value on acceptance
    task automatic send_beat(input t_op op, input logic [31:0] angle,
                             input logic known, input logic [31:0] typed);
        t_due_value due;
        int         gap;
        gap = 0;
        while ($urandom_range(0, 99) < SND_IDLE_PCT[phase]) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_angle    <= angle;
        do @(posedge i_clk); while (o_in_stall);
        due.value = known ? typed : series_value(op, angle);
        due.op    = op;
        due.angle = angle;
        due_values.push_back(due);
    endtask

    // input side, then drain and verdict
    initial begin
        t_stim_row row;
        t_op       op_pick;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < N_DIRECTED; k++) begin
            row = DIRECTED[k];
            send_beat(row.op, row.angle, row.known, row.value);
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 3) phase <= 1;
            else if (k == 2 * N_RANDOM / 3) phase <= 2;
            op_pick = t_op'($urandom_range(0, 1));
            send_beat(op_pick, random_angle(), 1'b0, 32'h0);
        end
        i_in_valid <= 1'b0;
        while (due_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && due_values.size() == 0)
            $display("** sine_cosine_series: PASSED **");
        else
            $display("** sine_cosine_series: FAILED **");
        $finish;
    end

    // output side stall; one long hold-off when the last phase starts
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (phase == 2 && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < RCV_IDLE_PCT[phase]);
        end
    end

    // check each output beat against the oldest recorded value
    always @(posedge i_clk) begin
        t_due_value due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_values.size() == 0) begin
                $error("value: unexpected beat, actual %0d", $signed(o_value));
                fail_cnt++;
            end else begin
                due = due_values.pop_front();
                if (o_value !== due.value) begin
                    $error("value: expected %0d, actual %0d (op %0d, angle %h)",
                           $signed(due.value), $signed(o_value), due.op, due.angle);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #2000000;
        $display("** sine_cosine_series: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/scs_pkg.sv
hw/rtl/scs_mul.sv
hw/rtl/sine_cosine_series.sv
tb/tb_sine_cosine_series.sv
